### rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  localparam int REQ_W = 13;
  localparam int OFF_W = 12;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage
`default_nettype wire

### rtl/ffha_ram.sv
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/first_fit_heap_allocator.sv
`default_nettype none
// first-fit allocator over an implicit header list kept in one single-port-read RAM
// a zero or rejected request goes straight to the result; a free reads its header and
// writes it back as free; an allocate walks the headers and looks past each too-small free block
// one request in flight; the next is taken once its result is registered, which may wait
// reset (rst_n low, synchronous) starts a clearing pass over all HEAP_BYTES/ALIGN_BYTES
// header slots that writes the initial free block; no request is taken until it ends
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES      = 4096,
  parameter int ALIGN_BYTES     = 8,
  parameter int HEADER_BYTES    = 8,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [12:0] request_bytes, [24:13] release_offset, [31:25] zero
  input  wire logic [ffha_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] command
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] payload_offset, [15:12] zero
  output logic      [ffha_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] granted
  output logic                                     out_tuser
);

  import ffha_pkg::*;

  localparam int GRANULES  = HEAP_BYTES / ALIGN_BYTES;
  localparam int ARENA_END = GRANULES * ALIGN_BYTES;
  localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
  localparam int ENTRY_W   = $clog2(ARENA_END) + 2;
  localparam int POS_W     = ENTRY_W + 1;
  localparam int IDX_W     = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  localparam int NEED_W    = REQ_W + 1;
  localparam int CMP_W     = (POS_W > NEED_W) ? POS_W : NEED_W;
  localparam int MIN_NEED  = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR,
    ST_NXT,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [ENTRY_W-1:0]  sz_r, sz_nxt;
  logic [ENTRY_W-1:0]  fwd_r, fwd_nxt;
  logic                use_fwd_r, use_fwd_nxt;
  logic                res_g_r, res_g_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_g_r, out_g_nxt;
  logic [OFF_W-1:0]    out_off_r, out_off_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic                cmd;
  logic [REQ_W-1:0]    req;
  logic [OFF_W-1:0]    rel;
  logic [NEED_W-1:0]   need_raw, need_rnd;
  logic [OFF_W-1:0]    hdr_off;
  logic [31:0]         hdr_idx32;
  logic                free_ok;

  logic [ENTRY_W-1:0]  hdr_e, hdr_sz, nxt_sz;
  logic [POS_W-1:0]    hdr_sum, nxt_sum;
  logic                hdr_bad, nxt_bad, hdr_fits;

  ffha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd = in_tuser;
  assign req = in_tdata[REQ_W-1:0];
  assign rel = in_tdata[REQ_W +: OFF_W];

  // request size plus header, rounded to the alignment, at least the minimum block
  assign need_raw = NEED_W'(req) + NEED_W'(HEADER_BYTES) + NEED_W'(ALIGN_BYTES - 1);
  always_comb begin
    need_rnd = need_raw & ~NEED_W'(ALIGN_BYTES - 1);
    if (need_rnd < NEED_W'(MIN_NEED)) begin
      need_rnd = NEED_W'(MIN_NEED);
    end
  end

  assign hdr_off   = rel - OFF_W'(HEADER_BYTES);
  assign hdr_idx32 = 32'(hdr_off) >> ALIGN_SH;
  assign free_ok   = (32'(rel) >= 32'(HEADER_BYTES))
                  && (hdr_off[ALIGN_SH-1:0] == '0)
                  && (hdr_idx32 < 32'(GRANULES));

  // header under inspection comes from the ram or from the last merge / read-ahead
  assign hdr_e    = use_fwd_r ? fwd_r : ram_rdata;
  assign hdr_sz   = hdr_e & ~ENTRY_W'(1);
  assign hdr_bad  = (hdr_sz == '0) || (hdr_sz[ALIGN_SH-1:0] != '0);
  assign hdr_sum  = pos_r + POS_W'(hdr_sz);
  assign hdr_fits = CMP_W'(hdr_sz) >= CMP_W'(need_r);

  assign nxt_sz   = ram_rdata & ~ENTRY_W'(1);
  assign nxt_bad  = (nxt_sz == '0) || (nxt_sz[ALIGN_SH-1:0] != '0);
  assign nxt_sum  = pos_r + POS_W'(sz_r);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    pos_nxt       = pos_r;
    need_nxt      = need_r;
    sz_nxt        = sz_r;
    fwd_nxt       = fwd_r;
    use_fwd_nxt   = use_fwd_r;
    res_g_nxt     = res_g_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    out_g_nxt     = out_g_r;
    out_off_nxt   = out_off_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[ALIGN_SH +: IDX_W];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = pos_r[ALIGN_SH +: IDX_W];
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = (clr_idx_r == '0) ? ENTRY_W'(ARENA_END) : '0;
        if (32'(clr_idx_r) == 32'(GRANULES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        in_tready   = 1'b1;
        res_g_nxt   = 1'b0;
        res_off_nxt = '0;
        if (in_tvalid) begin
          if (cmd == CMD_ALLOC) begin
            if (req == '0) begin
              state_nxt = ST_RESP;
            end else begin
              need_nxt    = need_rnd;
              pos_nxt     = '0;
              use_fwd_nxt = 1'b0;
              ram_re      = 1'b1;
              ram_raddr   = '0;
              state_nxt   = ST_HDR;
            end
          end else if (free_ok) begin
            pos_nxt   = POS_W'(32'(hdr_off));
            state_nxt = ST_FREE_RD;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_HDR: begin
        use_fwd_nxt = 1'b0;
        if (hdr_bad) begin
          state_nxt = ST_RESP;
        end else if (!hdr_e[0] && hdr_fits) begin
          ram_we      = 1'b1;
          ram_wdata   = hdr_sz | ENTRY_W'(1);
          res_g_nxt   = 1'b1;
          res_off_nxt = OFF_W'(pos_r + POS_W'(HEADER_BYTES));
          state_nxt   = ST_RESP;
        end else if (hdr_sum < POS_W'(ARENA_END)) begin
          ram_re    = 1'b1;
          ram_raddr = hdr_sum[ALIGN_SH +: IDX_W];
          if (!hdr_e[0]) begin
            // too small and free: look at the following header for a merge
            sz_nxt    = hdr_sz;
            state_nxt = ST_NXT;
          end else begin
            pos_nxt = hdr_sum;
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end

      ST_NXT: begin
        if (!ram_rdata[0]) begin
          if (nxt_bad) begin
            state_nxt = ST_RESP;
          end else begin
            ram_we      = 1'b1;
            ram_wdata   = sz_r + nxt_sz;
            fwd_nxt     = sz_r + nxt_sz;
            use_fwd_nxt = 1'b1;
            state_nxt   = ST_HDR;
          end
        end else begin
          // following block is in use: it is the next header to walk
          pos_nxt     = nxt_sum;
          fwd_nxt     = ram_rdata;
          use_fwd_nxt = 1'b1;
          state_nxt   = ST_HDR;
        end
      end

      ST_FREE_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_FREE_WR;
      end

      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~ENTRY_W'(1);
        res_g_nxt = 1'b1;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_g_nxt     = res_g_r;
          out_off_nxt   = res_off_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      use_fwd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      use_fwd_r   <= use_fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    need_r    <= need_nxt;
    sz_r      <= sz_nxt;
    fwd_r     <= fwd_nxt;
    res_g_r   <= res_g_nxt;
    res_off_r <= res_off_nxt;
    out_g_r   <= out_g_nxt;
    out_off_r <= out_off_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_g_r;
  assign out_tdata  = {(OUT_TDATA_W - OFF_W)'(0), out_off_r};

endmodule
`default_nettype wire
